// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define EMG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define EMG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/emg_pkg.sv =====
// ----------------------------------------------------------------------------
// emg_pkg
// Widths, constants and control types of the EMG level to servo angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package emg_pkg;

    localparam int RMS_BITS        = 16;
    localparam int LEVEL_FRAC_BITS = 16;
    localparam int ANGLE_W         = 16;
    localparam int CFG_IDX_W       = 8;
    localparam int CNT_W           = $clog2(LEVEL_FRAC_BITS);

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL = CFG_IDX_W'(1);

    // Q8.8 angle limits and steps
    localparam int ANGLE_LOW  = 15360;
    localparam int ANGLE_HIGH = 35840;
    localparam int ANGLE_SPAN = 20480;
    localparam int SLEW_MAX   = 1536;
    localparam int WRITE_EPS  = 128;

    // deadzone, 0.05 of full scale rounded
    localparam int DEADZONE = ((1 << LEVEL_FRAC_BITS) + 10) / 20;

    // divide by 5 through a reciprocal multiply
    localparam int EMA_SUM_W    = LEVEL_FRAC_BITS + 3;
    localparam int DIV5_SHIFT   = LEVEL_FRAC_BITS + 6;
    localparam int DIV5_MULT    = ((1 << DIV5_SHIFT) + 4) / 5;
    localparam int DIV5_MULT_W  = DIV5_SHIFT - 2;

    typedef struct packed {
        logic load;
        logic div_step;
        logic ema;
        logic map;
        logic slew;
    } t_cmd;

    typedef struct packed {
        logic skip_div;
        logic div_last;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/emg_if.sv =====
// ----------------------------------------------------------------------------
// emg_if
// Valid/ready channels of the block: rms input, servo result, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface emg_in_if;
    logic                          valid;
    logic                          ready;
    logic [emg_pkg::RMS_BITS-1:0]  rms_value;

    modport source (output valid, output rms_value, input ready);
    modport sink   (input valid, input rms_value, output ready);
endinterface

interface emg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [emg_pkg::ANGLE_W-1:0]          servo_angle;
    logic                                 servo_write;
    logic [emg_pkg::LEVEL_FRAC_BITS-1:0]  smoothed_activation;

    modport source (output valid, output servo_angle, output servo_write,
                    output smoothed_activation, input ready);
    modport sink   (input valid, input servo_angle, input servo_write,
                    input smoothed_activation, output ready);
endinterface

interface emg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [emg_pkg::CFG_IDX_W-1:0]  index;
    logic [emg_pkg::RMS_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/emg_level_to_slewed_servo_angle.sv =====
// An accepted item first takes the RMS value, then the restoring divider
// forms the Q0.16 level one quotient bit per cycle, then the EMA, the angle
// map and the slew step follow in that order. When the level needs no
// division (full not above rest, value at or below rest, or at or above full)
// the divider is passed over. A new value is taken once the previous one has
// reached the output register, even if that result has not yet been claimed.
// Writing either calibration register returns the smoothed level to 0 and the
// angle to 60 degrees; writes are accepted every cycle.
// ----------------------------------------------------------------------------
// emg_level_to_slewed_servo_angle
// EMG RMS level to smoothed, rate-limited Q8.8 servo angle.
// ----------------------------------------------------------------------------
`default_nettype none

module emg_level_to_slewed_servo_angle (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    emg_in_if.sink      i_rms,
    emg_out_if.source   o_res,
    emg_cfg_if.sink     i_cfg
);

    emg_pkg::t_cmd  w_cmd;
    emg_pkg::t_stat w_stat;
    logic           w_cfg_we;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid && i_cfg.ready;

    emg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rms.valid),
        .o_in_ready  (i_rms.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    emg_dpath u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_rms_value           (i_rms.rms_value),
        .i_cfg_we              (w_cfg_we),
        .i_cfg_index           (i_cfg.index),
        .i_cfg_data            (i_cfg.data),
        .o_servo_angle         (o_res.servo_angle),
        .o_servo_write         (o_res.servo_write),
        .o_smoothed_activation (o_res.smoothed_activation)
    );

endmodule

`default_nettype wire

// ===== src/emg_ctrl.sv =====
// ----------------------------------------------------------------------------
// emg_ctrl
// Sequencer: accept, divide, smooth, map, slew and hand the word to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module emg_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire emg_pkg::t_stat i_stat,
    output emg_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_EMA  = 5'b00100,
        S_MAP  = 5'b01000,
        S_SLEW = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = !i_stat.skip_div;
                if (i_stat.skip_div || i_stat.div_last) begin
                    n_state = S_EMA;
                end
            end
            S_EMA: begin
                o_cmd.ema = 1'b1;
                n_state   = S_MAP;
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_SLEW;
            end
            S_SLEW: begin
                // wait here only while the previous word is still unclaimed
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.slew = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.slew) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/emg_dpath.sv =====
// ----------------------------------------------------------------------------
// emg_dpath
// Calibration registers, restoring divider, EMA, angle map, slew limit, output.
// ----------------------------------------------------------------------------
`default_nettype none

module emg_dpath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire emg_pkg::t_cmd                        i_cmd,
    output emg_pkg::t_stat                            o_stat,
    input  wire logic [emg_pkg::RMS_BITS-1:0]         i_rms_value,
    input  wire logic                                 i_cfg_we,
    input  wire logic [emg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [emg_pkg::RMS_BITS-1:0]         i_cfg_data,
    output logic [emg_pkg::ANGLE_W-1:0]               o_servo_angle,
    output logic                                      o_servo_write,
    output logic [emg_pkg::LEVEL_FRAC_BITS-1:0]       o_smoothed_activation
);

    localparam int RW = emg_pkg::RMS_BITS;
    localparam int LW = emg_pkg::LEVEL_FRAC_BITS;
    localparam int AW = emg_pkg::ANGLE_W;
    localparam int SW = emg_pkg::EMA_SUM_W;
    localparam int MW = emg_pkg::DIV5_MULT_W;

    localparam logic [AW-1:0]          ANGLE_LOW  = AW'(emg_pkg::ANGLE_LOW);
    localparam logic [AW-1:0]          ANGLE_SPAN = AW'(emg_pkg::ANGLE_SPAN);
    localparam logic signed [AW:0]     LOW_S      = (AW+1)'(emg_pkg::ANGLE_LOW);
    localparam logic signed [AW:0]     HIGH_S     = (AW+1)'(emg_pkg::ANGLE_HIGH);
    localparam logic signed [AW:0]     SLEW_P     = (AW+1)'(emg_pkg::SLEW_MAX);
    localparam logic signed [AW:0]     SLEW_N     = -((AW+1)'(emg_pkg::SLEW_MAX));
    localparam logic [AW:0]            EPS        = (AW+1)'(emg_pkg::WRITE_EPS);
    localparam logic [LW-1:0]          DEADZONE   = LW'(emg_pkg::DEADZONE);
    localparam logic [MW-1:0]          DIV5_MULT  = MW'(emg_pkg::DIV5_MULT);
    localparam logic [emg_pkg::CNT_W-1:0] CNT_LAST = emg_pkg::CNT_W'(LW - 1);

    logic [RW-1:0]              r_rest, r_full;
    logic [RW-1:0]              r_rem;
    logic [LW-1:0]              r_quo;
    logic [emg_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_skip;
    logic [LW-1:0]              r_ema;
    logic [AW-1:0]              r_target;
    logic [AW-1:0]              r_cur;
    logic [AW-1:0]              r_last;
    logic                       r_has;
    logic [AW-1:0]              r_out_angle;
    logic                       r_out_write;
    logic [LW-1:0]              r_out_act;

    logic [RW-1:0]              w_den;
    logic [RW:0]                w_shift;
    logic                       w_fits;
    logic [LW-1:0]              w_level;
    logic [SW-1:0]              w_sum;
    logic [SW+MW-1:0]           w_div5;
    logic [AW+LW-1:0]           w_span;
    logic signed [AW:0]         w_delta;
    logic signed [AW:0]         w_new_s;
    logic [AW-1:0]              w_new;
    logic signed [AW:0]         w_diff;
    logic [AW:0]                w_abs;
    logic                       w_write;

    assign w_den   = r_full - r_rest;
    assign w_shift = {r_rem, 1'b0};
    assign w_fits  = (w_shift >= {1'b0, w_den});

    // levels inside the deadzone snap to zero
    assign w_level = (r_quo < DEADZONE) ? '0 : r_quo;
    assign w_sum   = {1'b0, r_ema, 2'b00} + SW'(w_level);
    assign w_div5  = (SW+MW)'(w_sum) * (SW+MW)'(DIV5_MULT);
    assign w_span  = (AW+LW)'(r_ema) * (AW+LW)'(ANGLE_SPAN);

    always_comb begin
        w_delta = $signed({1'b0, r_target}) - $signed({1'b0, r_cur});
        if (w_delta > SLEW_P) begin
            w_delta = SLEW_P;
        end else if (w_delta < SLEW_N) begin
            w_delta = SLEW_N;
        end
        w_new_s = $signed({1'b0, r_cur}) + w_delta;
        if (w_new_s < LOW_S) begin
            w_new_s = LOW_S;
        end else if (w_new_s > HIGH_S) begin
            w_new_s = HIGH_S;
        end
        w_new  = w_new_s[AW-1:0];
        w_diff = $signed({1'b0, w_new}) - $signed({1'b0, r_last});
        w_abs  = (w_diff < 0) ? $unsigned(-w_diff) : $unsigned(w_diff);
        w_write = !r_has || (w_abs >= EPS);
    end

    // calibration and the state that survives between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= '0;
            r_full <= '0;
            r_ema  <= '0;
            r_cur  <= ANGLE_LOW;
            r_last <= '0;
            r_has  <= 1'b0;
        end else if (i_cfg_we &&
                     (i_cfg_index == emg_pkg::REG_REST_LEVEL ||
                      i_cfg_index == emg_pkg::REG_FULL_LEVEL)) begin
            if (i_cfg_index == emg_pkg::REG_REST_LEVEL) begin
                r_rest <= i_cfg_data;
            end else begin
                r_full <= i_cfg_data;
            end
            r_ema <= '0;
            r_cur <= ANGLE_LOW;
        end else begin
            if (i_cmd.ema) begin
                r_ema <= w_div5[emg_pkg::DIV5_SHIFT +: LW];
            end
            if (i_cmd.slew) begin
                r_cur <= w_new;
                if (w_write) begin
                    r_last <= w_new;
                    r_has  <= 1'b1;
                end
            end
        end
    end

    // divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
            if (r_full <= r_rest || i_rms_value <= r_rest) begin
                r_skip <= 1'b1;
            end else if (i_rms_value >= r_full) begin
                r_skip <= 1'b1;
            end else begin
                r_skip <= 1'b0;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_rms_value - r_rest;
            if (r_full <= r_rest || i_rms_value <= r_rest) begin
                r_quo <= '0;
            end else if (i_rms_value >= r_full) begin
                r_quo <= '1;
            end else begin
                r_quo <= '0;
            end
        end else if (i_cmd.div_step) begin
            if (w_fits) begin
                r_rem <= RW'(w_shift - {1'b0, w_den});
                r_quo <= {r_quo[LW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[RW-1:0];
                r_quo <= {r_quo[LW-2:0], 1'b0};
            end
        end
        if (i_cmd.map) begin
            r_target <= ANGLE_LOW + w_span[LW +: AW];
        end
        if (i_cmd.slew) begin
            r_out_angle <= w_new;
            r_out_write <= w_write;
            r_out_act   <= r_ema;
        end
    end

    assign o_stat.skip_div = r_skip;
    assign o_stat.div_last = (r_cnt == CNT_LAST);

    assign o_servo_angle         = r_out_angle;
    assign o_servo_write         = r_out_write;
    assign o_smoothed_activation = r_out_act;

endmodule

`default_nettype wire

// ===== src/emg_checker.sv =====
// ----------------------------------------------------------------------------
// emg_checker
// Port-level checks of the servo angle block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module emg_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    input  wire logic                                 i_in_ready,
    input  wire logic                                 i_out_valid,
    input  wire logic                                 i_out_ready,
    input  wire logic [emg_pkg::ANGLE_W-1:0]          i_servo_angle,
    input  wire logic                                 i_servo_write,
    input  wire logic [emg_pkg::LEVEL_FRAC_BITS-1:0]  i_smoothed_activation
);

    localparam int AW = emg_pkg::ANGLE_W;

    logic               r_have;
    logic [AW-1:0]      r_last;
    logic               w_in_acc;
    logic               w_out_acc;
    logic signed [AW:0] w_diff;
    logic [AW:0]        w_abs;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;
    assign w_diff    = $signed({1'b0, i_servo_angle}) - $signed({1'b0, r_last});
    assign w_abs     = (w_diff < 0) ? $unsigned(-w_diff) : $unsigned(w_diff);

    // last angle that went out with a write flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_last <= '0;
        end else if (w_out_acc && i_servo_write) begin
            r_have <= 1'b1;
            r_last <= i_servo_angle;
        end
    end

    `EMG_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_acc, !i_in_ready, "input taken while busy")

    `EMG_ASSERT_NOW(a_angle_range, i_clk, i_rst_n, i_out_valid, (i_servo_angle >= AW'(emg_pkg::ANGLE_LOW) && i_servo_angle <= AW'(emg_pkg::ANGLE_HIGH)), "servo angle out of range")

    `EMG_ASSERT_NOW(a_write_flag, i_clk, i_rst_n, w_out_acc && !i_servo_write, r_have && (w_abs < (AW+1)'(emg_pkg::WRITE_EPS)), "missing servo write")

    `EMG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_servo_angle) && $stable(i_servo_write) && $stable(i_smoothed_activation), "stalled result changed")

endmodule

bind emg_level_to_slewed_servo_angle emg_checker u_emg_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_rms.valid),
    .i_in_ready            (i_rms.ready),
    .i_out_valid           (o_res.valid),
    .i_out_ready           (o_res.ready),
    .i_servo_angle         (o_res.servo_angle),
    .i_servo_write         (o_res.servo_write),
    .i_smoothed_activation (o_res.smoothed_activation)
);

`default_nettype wire

// ===== bench/emg_level_to_slewed_servo_angle_tb.sv =====
// ----------------------------------------------------------------------------
// emg_level_to_slewed_servo_angle_tb
// Drives rms words through the servo angle block under several calibration
// settings, predicts every servo word in step with the input handshake and
// compares each returned word field by field, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module emg_level_to_slewed_servo_angle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import emg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PATTERN} ready_mode_e;

    typedef struct packed {
        logic [ANGLE_W-1:0]         angle;
        logic                       write;
        logic [LEVEL_FRAC_BITS-1:0] activation;
    } servo_word_t;

    logic i_clk;
    logic i_rst_n = 1'b0;

    emg_in_if  rms_if ();
    emg_out_if res_if ();
    emg_cfg_if cfg_if ();

    logic                 rms_valid = 1'b0;
    logic [RMS_BITS-1:0]  rms_word  = '0;
    logic                 res_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RMS_BITS-1:0]  cfg_data  = '0;

    assign rms_if.valid     = rms_valid;
    assign rms_if.rms_value = rms_word;
    assign res_if.ready     = res_ready;
    assign cfg_if.valid     = cfg_valid;
    assign cfg_if.index     = cfg_index;
    assign cfg_if.data      = cfg_data;

    emg_level_to_slewed_servo_angle u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rms   (rms_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // predictor state
    logic [RMS_BITS-1:0]        rest_cal = '0;
    logic [RMS_BITS-1:0]        full_cal = '0;
    logic [LEVEL_FRAC_BITS-1:0] act_smooth = '0;
    int                         angle_now  = ANGLE_LOW;
    int                         angle_sent = 0;
    logic                       angle_sent_valid = 1'b0;

    logic [RMS_BITS-1:0] rms_pending[$];
    servo_word_t         servo_expected[$];
    servo_word_t         want_word;

    ready_mode_e recv_mode = RDY_ALWAYS;
    int          gap_max   = 0;
    int          burst_left, gap_left;
    int          hold_left, results_seen, ready_tick;
    int          fail_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic servo_word_t predict_servo(input logic [RMS_BITS-1:0] rms);
        logic [RMS_BITS-1:0]        above_rest;
        logic [31:0]                quot;
        logic [LEVEL_FRAC_BITS-1:0] level;
        int                         target, step, diff;
        servo_word_t                r;
        if (full_cal <= rest_cal || rms <= rest_cal) begin
            level = '0;
        end else if (rms >= full_cal) begin
            level = '1;
        end else begin
            above_rest = rms - rest_cal;
            quot = {above_rest, 16'h0000} / {16'h0000, full_cal - rest_cal};
            if (quot > 32'hFFFF) quot = 32'hFFFF;
            level = (quot < DEADZONE) ? '0 : quot[15:0];
        end
        act_smooth = LEVEL_FRAC_BITS'((4 * int'(act_smooth) + int'(level)) / 5);
        target = ANGLE_LOW + ((ANGLE_SPAN * int'(act_smooth)) >>> LEVEL_FRAC_BITS);
        step = target - angle_now;
        if (step > SLEW_MAX) step = SLEW_MAX;
        if (step < -SLEW_MAX) step = -SLEW_MAX;
        angle_now = angle_now + step;
        if (angle_now < ANGLE_LOW) angle_now = ANGLE_LOW;
        if (angle_now > ANGLE_HIGH) angle_now = ANGLE_HIGH;
        diff = angle_now - angle_sent;
        if (diff < 0) diff = -diff;
        r.write = !angle_sent_valid || diff >= WRITE_EPS;
        if (r.write) begin
            angle_sent = angle_now;
            angle_sent_valid = 1'b1;
        end
        r.angle = ANGLE_W'(angle_now);
        r.activation = act_smooth;
        return r;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rms_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (rms_valid && rms_if.ready) servo_expected.push_back(predict_servo(rms_word));
            if (!rms_valid || rms_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rms_valid <= 1'b0;
                end else if (rms_pending.size() > 0) begin
                    rms_valid <= 1'b1;
                    rms_word <= rms_pending.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end else begin
                    rms_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each servo word, stalls per mode, long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            hold_left = 0;
            results_seen = 0;
            ready_tick = 0;
        end else begin
            if (res_if.valid && res_ready) begin
                if (servo_expected.size() == 0) begin
                    $display("%0t unexpected servo word: angle %0d write %0d activation %0d",
                             $time, res_if.servo_angle, res_if.servo_write,
                             res_if.smoothed_activation);
                    fail_count++;
                end else begin
                    want_word = servo_expected.pop_front();
                    if (res_if.servo_angle !== want_word.angle) begin
                        $display("%0t servo_angle: expected %0d, actual %0d",
                                 $time, want_word.angle, res_if.servo_angle);
                        fail_count++;
                    end
                    if (res_if.servo_write !== want_word.write) begin
                        $display("%0t servo_write: expected %0d, actual %0d",
                                 $time, want_word.write, res_if.servo_write);
                        fail_count++;
                    end
                    if (res_if.smoothed_activation !== want_word.activation) begin
                        $display("%0t smoothed_activation: expected %0d, actual %0d",
                                 $time, want_word.activation, res_if.smoothed_activation);
                        fail_count++;
                    end
                end
                results_seen++;
                // back up the pipe so the input side stalls
                if (results_seen == 100 || results_seen == 700) hold_left = HOLD_CYCLES;
            end
            ready_tick++;
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else begin
                case (recv_mode)
                    RDY_ALWAYS:  res_ready <= 1'b1;
                    RDY_MOSTLY:  res_ready <= ($urandom_range(0, 3) != 0);
                    RDY_RARELY:  res_ready <= ($urandom_range(0, 3) == 0);
                    default:     res_ready <= ((ready_tick % 7) < 4);
                endcase
            end
        end
    end

    task automatic write_calibration(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [RMS_BITS-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == REG_REST_LEVEL || idx == REG_FULL_LEVEL) begin
            if (idx == REG_REST_LEVEL) rest_cal = value;
            else full_cal = value;
            act_smooth = '0;
            angle_now = ANGLE_LOW;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (rms_pending.size() != 0 || rms_valid || servo_expected.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // sustained flexes of random strength, plus values outside the range
    task automatic load_random_levels(input int count);
        int                  run, pick;
        logic [RMS_BITS-1:0] val;
        while (count > 0) begin
            run = $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            if (pick < 6 && full_cal > rest_cal)
                val = RMS_BITS'(rest_cal + $urandom_range(0, full_cal - rest_cal));
            else if (pick < 7)
                val = RMS_BITS'($urandom_range(0, rest_cal));
            else if (pick < 8)
                val = RMS_BITS'($urandom_range(full_cal, 16'hFFFF));
            else
                val = RMS_BITS'($urandom_range(0, 16'hFFFF));
            while (run > 0 && count > 0) begin
                rms_pending.push_back(val);
                run--;
                count--;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // range left unset after reset
        rms_pending.push_back(16'd0); rms_pending.push_back(16'hFFFF);
        wait_idle();

        write_calibration(REG_REST_LEVEL, 16'd1000);
        write_calibration(REG_FULL_LEVEL, 16'd5000);
        // at rest, below, just above, either side of the deadzone, full, beyond
        rms_pending.push_back(16'd1000); rms_pending.push_back(16'd999);
        rms_pending.push_back(16'd1001); rms_pending.push_back(16'd1200);
        rms_pending.push_back(16'd1201); rms_pending.push_back(16'd4999);
        rms_pending.push_back(16'd5000);
        repeat (4) rms_pending.push_back(16'hFFFF);
        repeat (2) rms_pending.push_back(16'd0);
        wait_idle();

        // unknown indexes must leave the smoothing untouched
        write_calibration(REG_SPARE, 16'hFFFF);
        write_calibration(REG_TOP, 16'h0000);
        rms_pending.push_back(16'd3000);
        wait_idle();

        write_calibration(REG_REST_LEVEL, 16'd0);
        write_calibration(REG_FULL_LEVEL, 16'hFFFF);
        rms_pending.push_back(16'hFFFE); rms_pending.push_back(16'hFFFF);
        rms_pending.push_back(16'd1);
        wait_idle();

        // full below rest, then full equal to rest
        write_calibration(REG_REST_LEVEL, 16'hFFFF);
        write_calibration(REG_FULL_LEVEL, 16'd0);
        rms_pending.push_back(16'hFFFF);
        wait_idle();
        write_calibration(REG_REST_LEVEL, 16'd40000);
        write_calibration(REG_FULL_LEVEL, 16'd40000);
        rms_pending.push_back(16'd40000);
        wait_idle();

        // narrowest range
        write_calibration(REG_REST_LEVEL, 16'd0);
        write_calibration(REG_FULL_LEVEL, 16'd1);
        rms_pending.push_back(16'd1); rms_pending.push_back(16'd0);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_calibration(REG_REST_LEVEL, 16'd0);
                    write_calibration(REG_FULL_LEVEL, 16'hFFFF);
                    recv_mode = RDY_ALWAYS;
                    gap_max = 0;
                end
                1: begin
                    write_calibration(REG_REST_LEVEL, RMS_BITS'($urandom_range(0, 2000)));
                    write_calibration(REG_FULL_LEVEL,
                                      RMS_BITS'(rest_cal + $urandom_range(500, 20000)));
                    recv_mode = RDY_MOSTLY;
                    gap_max = 3;
                end
                2: begin
                    write_calibration(REG_REST_LEVEL, RMS_BITS'($urandom_range(0, 16'hFFFF)));
                    write_calibration(REG_FULL_LEVEL, RMS_BITS'($urandom_range(0, 16'hFFFF)));
                    recv_mode = RDY_RARELY;
                    gap_max = 30;
                end
                3: begin
                    write_calibration(REG_FULL_LEVEL, 16'hFFFF);
                    write_calibration(REG_REST_LEVEL, 16'd65000);
                    recv_mode = RDY_PATTERN;
                    gap_max = 8;
                end
                default: begin
                    write_calibration(REG_REST_LEVEL, RMS_BITS'($urandom_range(0, 60000)));
                    write_calibration(REG_FULL_LEVEL,
                                      RMS_BITS'(rest_cal + $urandom_range(1, 50)));
                    recv_mode = RDY_MOSTLY;
                    gap_max = 0;
                end
            endcase
            load_random_levels(200);
            wait_idle();
        end

        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/emg_pkg.sv
src/emg_if.sv
src/emg_ctrl.sv
src/emg_dpath.sv
src/emg_level_to_slewed_servo_angle.sv
src/emg_checker.sv
bench/emg_level_to_slewed_servo_angle_tb.sv
